@@ design/tnsc_pkg.sv @@
package tnsc_pkg;

    // request kinds
    localparam logic [1:0] KIND_SET_ACTIVE = 2'd0;
    localparam logic [1:0] KIND_MARK       = 2'd1;
    localparam logic [1:0] KIND_FETCH      = 2'd2;
    localparam logic [1:0] KIND_DISARM     = 2'd3;

    // field widths
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int TRACK_W = 4;
    localparam int STEP_W  = 6;
    localparam int SLOT_W  = 2;

    // tag value meaning no active bank or pattern
    localparam logic [BYTE_W-1:0] NO_TAG = 8'hFF;

    // reset value of the default velocity register
    localparam logic [BYTE_W-1:0] DEFAULT_VEL_RST = 8'd100;

    // generation counter kept with each row of armed marks
    localparam int                EPOCH_W   = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    // stored note data: note, velocity, length
    typedef struct packed {
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] velocity;
        logic [BYTE_W-1:0] length;
    } note_data_t;

endpackage

@@ design/tnsc_if.sv @@
interface tnsc_req_if;
    import tnsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   bank;
    logic [BYTE_W-1:0]   pattern;
    logic [TRACK_W-1:0]  track;
    logic [STEP_W-1:0]   step_index;
    logic [SLOT_W-1:0]   slot;
    logic [BYTE_W-1:0]   note_in;
    logic [BYTE_W-1:0]   velocity_in;
    logic [BYTE_W-1:0]   length_in;

    modport source (
        output valid, kind, bank, pattern, track, step_index, slot,
               note_in, velocity_in, length_in,
        input  ready
    );

    modport sink (
        input  valid, kind, bank, pattern, track, step_index, slot,
               note_in, velocity_in, length_in,
        output ready
    );
endinterface

interface tnsc_rsp_if;
    import tnsc_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [BYTE_W-1:0]  note_out;
    logic [BYTE_W-1:0]  velocity_out;
    logic [BYTE_W-1:0]  length_out;

    modport source (
        output valid, hit, note_out, velocity_out, length_out,
        input  ready
    );

    modport sink (
        input  valid, hit, note_out, velocity_out, length_out,
        output ready
    );
endinterface

interface tnsc_cfg_if;
    import tnsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ design/tnsc_ram.sv @@
module tnsc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ design/tagged_note_slot_cache_core.sv @@
// channel | dir | handshake     | carries
// --------+-----+---------------+-----------------------------------------------
// req     | in  | valid/ready   | kind, bank, pattern, track, step_index, slot,
//         |     |               | note_in, velocity_in, length_in
// rsp     | out | valid/ready   | hit, note_out, velocity_out, length_out
// cfg     | in  | valid/ready   | data: default velocity
//
// one request per cycle unless stalled; a fetch result passes the second stage and the
// result register to rsp. the armed-mark RAM is read at accept and written back as the
// request leaves the second stage, forwarding the last write-back, so back-to-back
// requests to one row work. after reset, and when a tag change finds the epoch at its
// maximum (the 256th change after reset, then every 255th), the core drains and sweeps
// the armed-mark RAM, one row a cycle, through all TRACKS*STEPS rows (1024 by default).
// a result held on rsp stalls a fetch in the second stage, and the input behind it.
module tagged_note_slot_cache_core #(
    parameter int TRACKS = 16,
    parameter int STEPS  = 64,
    parameter int SLOTS  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    tnsc_req_if.sink          req,
    tnsc_rsp_if.source        rsp,
    tnsc_cfg_if.sink          cfg
);
    import tnsc_pkg::*;

    localparam int ROWS       = TRACKS * STEPS;
    localparam int ENTRIES    = ROWS * SLOTS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MROW_W     = EPOCH_W + SLOTS;
    localparam int DATA_W     = $bits(note_data_t);

    // controller states
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [SLOTS-1:0]   armed;
    } mark_row_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  act;
        logic [ROW_W-1:0]      row;
        logic [SLOT_IDX_W-1:0] slot;
        logic [EPOCH_W-1:0]    epoch;
    } stage_t;

    logic [1:0]         state_reg, state_next;
    logic [ROW_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [BYTE_W-1:0]  bank_tag_reg, bank_tag_next;
    logic [BYTE_W-1:0]  pattern_tag_reg, pattern_tag_next;
    logic [BYTE_W-1:0]  default_vel_reg, default_vel_next;

    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [ROW_W-1:0]   fwd_row_reg;
    mark_row_t          fwd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg;
    note_data_t         out_data_reg;

    logic               tag_match, ts_ok, addr_ok, tag_change, wrap_stall;
    logic               accept, s1_stall, s1_retire;
    logic [ROW_W-1:0]   row_idx;
    logic [ENT_W-1:0]   ent_idx;
    note_data_t         wr_note;

    mark_row_t          mrow_rd, mrow_cur, mrow_wr;
    logic [SLOTS-1:0]   armed_eff, slot_bit;
    logic               mem_wr_en;
    logic [ROW_W-1:0]   mem_wr_addr;
    mark_row_t          mem_wr_data;
    note_data_t         data_rd;
    logic               s1_hit;

    // request decode
    assign tag_match = (req.bank == bank_tag_reg) && (req.pattern == pattern_tag_reg);
    assign ts_ok     = (32'(req.track) < TRACKS) && (32'(req.step_index) < STEPS);
    assign addr_ok   = ts_ok && (32'(req.slot) < SLOTS);
    assign row_idx   = ROW_W'(32'(req.track) * STEPS + 32'(req.step_index));
    assign ent_idx   = ENT_W'(32'(row_idx) * SLOTS + 32'(req.slot));

    assign tag_change = !tag_match &&
                        ((req.kind == KIND_SET_ACTIVE) || ((req.kind == KIND_MARK) && addr_ok));
    assign wrap_stall = req.valid && tag_change && (epoch_reg == EPOCH_MAX);

    assign s1_stall  = s1_valid_reg && (s1_reg.kind == KIND_FETCH) && out_valid_reg && !rsp.ready;
    assign s1_retire = s1_valid_reg && !s1_stall;

    assign req.ready = (state_reg == ST_RUN) && !wrap_stall && !s1_stall;
    assign accept    = req.valid && req.ready;

    // stored note with defaults applied
    always_comb
    begin
        wr_note.note     = req.note_in;
        wr_note.velocity = (req.velocity_in == '0) ? default_vel_reg : req.velocity_in;
        wr_note.length   = (req.length_in == '0) ? 8'd1 : req.length_in;
    end

    // tag, epoch and sweep control
    always_comb
    begin
        state_next       = state_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        epoch_next       = epoch_reg;
        bank_tag_next    = bank_tag_reg;
        pattern_tag_next = pattern_tag_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (wrap_stall)
                begin
                    state_next = ST_DRAIN;
                end
                else if (accept && tag_change)
                begin
                    bank_tag_next    = req.bank;
                    pattern_tag_next = req.pattern;
                    epoch_next       = epoch_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg)
                begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                    epoch_next     = '0;
                end
            end
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // config register
    assign cfg.ready        = 1'b1;
    assign default_vel_next = cfg.valid ? cfg.data : default_vel_reg;

    // second stage entry
    always_comb
    begin
        s1_next.kind  = req.kind;
        s1_next.row   = row_idx;
        s1_next.slot  = SLOT_IDX_W'(req.slot);
        s1_next.epoch = tag_change ? epoch_reg + 1'b1 : epoch_reg;
        case (req.kind)
            KIND_MARK:   s1_next.act = addr_ok;
            KIND_FETCH:  s1_next.act = tag_match && addr_ok;
            KIND_DISARM: s1_next.act = tag_match && ts_ok;
            default:     s1_next.act = 1'b0;
        endcase
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_reg);

    // armed-mark read-modify-write
    assign mrow_cur  = (fwd_valid_reg && (fwd_row_reg == s1_reg.row)) ? fwd_data_reg : mrow_rd;
    assign armed_eff = (mrow_cur.epoch == s1_reg.epoch) ? mrow_cur.armed : '0;
    assign slot_bit  = SLOTS'(1) << s1_reg.slot;
    assign s1_hit    = s1_reg.act && ((armed_eff & slot_bit) != '0);

    always_comb
    begin
        mrow_wr.epoch = s1_reg.epoch;
        case (s1_reg.kind)
            KIND_MARK:   mrow_wr.armed = armed_eff | slot_bit;
            KIND_FETCH:  mrow_wr.armed = armed_eff & ~slot_bit;
            default:     mrow_wr.armed = '0;
        endcase
    end

    // write port: sweep or write-back
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_cnt_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = s1_retire && s1_reg.act;
            mem_wr_addr = s1_reg.row;
            mem_wr_data = mrow_wr;
        end
    end

    assign fwd_valid_next = (state_reg == ST_SWEEP) ? 1'b0 :
                            ((s1_retire && s1_reg.act) ? 1'b1 : fwd_valid_reg);

    // result register
    always_comb
    begin
        if (s1_retire && (s1_reg.kind == KIND_FETCH))
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    tnsc_ram #(
        .DEPTH (ROWS),
        .WIDTH (MROW_W)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (row_idx),
        .rd_data (mrow_rd)
    );

    tnsc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (DATA_W)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (accept && (req.kind == KIND_MARK) && addr_ok),
        .wr_addr (ent_idx),
        .wr_data (wr_note),
        .rd_en   (accept),
        .rd_addr (ent_idx),
        .rd_data (data_rd)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_cnt_reg   <= '0;
            epoch_reg       <= '0;
            bank_tag_reg    <= NO_TAG;
            pattern_tag_reg <= NO_TAG;
            default_vel_reg <= DEFAULT_VEL_RST;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            epoch_reg       <= epoch_next;
            bank_tag_reg    <= bank_tag_next;
            pattern_tag_reg <= pattern_tag_next;
            default_vel_reg <= default_vel_next;
            s1_valid_reg    <= s1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_retire && s1_reg.act)
        begin
            fwd_row_reg  <= s1_reg.row;
            fwd_data_reg <= mrow_wr;
        end
        if (s1_retire && (s1_reg.kind == KIND_FETCH))
        begin
            hit_reg      <= s1_hit;
            out_data_reg <= s1_hit ? data_rd : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.note_out     = out_data_reg.note;
    assign rsp.velocity_out = out_data_reg.velocity;
    assign rsp.length_out   = out_data_reg.length;
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tnsc_pkg::*;

    localparam int TRACKS        = 16;
    localparam int STEPS         = 64;
    localparam int SLOTS         = 4;
    localparam int ENTRIES       = TRACKS * STEPS * SLOTS;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 15;
    localparam int RANDOM_ITEMS_A = 40;
    localparam int RANDOM_ITEMS_B = 60;
    localparam int QUIET_ITEMS    = 30;
    localparam int CHURN_ROUNDS   = 260;
    localparam int CHURN_CHECK    = 4;
    localparam int RECENT_DEPTH   = 16;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  bank;
        logic [BYTE_W-1:0]  pattern;
        logic [TRACK_W-1:0] track;
        logic [STEP_W-1:0]  step_index;
        logic [SLOT_W-1:0]  slot;
        logic [BYTE_W-1:0]  note;
        logic [BYTE_W-1:0]  velocity;
        logic [BYTE_W-1:0]  length;
    } note_request_t;

    typedef struct packed {
        logic               hit;
        logic [BYTE_W-1:0]  note;
        logic [BYTE_W-1:0]  velocity;
        logic [BYTE_W-1:0]  length;
    } fetch_result_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [STEP_W-1:0]  step_index;
        logic [SLOT_W-1:0]  slot;
    } slot_addr_t;

    localparam int ADDR_W = $bits(slot_addr_t);

    // predicted cache contents and the fetch results still owed by the block
    class slot_cache_model;
        logic [BYTE_W-1:0] bank_tag;
        logic [BYTE_W-1:0] pattern_tag;
        logic [BYTE_W-1:0] default_vel;
        bit                armed [ENTRIES];
        note_data_t        stored [ENTRIES];
        fetch_result_t     owed_fetches [$];
        int                errors;
        int                requests_seen;
        int                results_checked;
        int                hits_checked;
        int                tag_changes;

        function new();
            bank_tag        = NO_TAG;
            pattern_tag     = NO_TAG;
            default_vel     = DEFAULT_VEL_RST;
            errors          = 0;
            requests_seen   = 0;
            results_checked = 0;
            hits_checked    = 0;
            tag_changes     = 0;
            foreach (armed[i]) armed[i] = 1'b0;
        endfunction

        function int pending();
            return owed_fetches.size();
        endfunction

        function void set_default_velocity(logic [BYTE_W-1:0] value);
            default_vel = value;
        endfunction

        // a new tag drops every armed mark
        function void switch_tag(logic [BYTE_W-1:0] bank, logic [BYTE_W-1:0] pattern);
            if (bank == bank_tag && pattern == pattern_tag)
                return;
            bank_tag    = bank;
            pattern_tag = pattern;
            tag_changes++;
            foreach (armed[i]) armed[i] = 1'b0;
        endfunction

        // apply one accepted request transaction
        function void note_request(note_request_t r);
            int            idx;
            int            row;
            bit            tag_ok;
            fetch_result_t res;
            idx    = int'({r.track, r.step_index, r.slot});
            row    = int'({r.track, r.step_index}) * SLOTS;
            tag_ok = (r.bank == bank_tag) && (r.pattern == pattern_tag);
            requests_seen++;
            case (r.kind)
                KIND_SET_ACTIVE: switch_tag(r.bank, r.pattern);
                KIND_MARK:
                begin
                    switch_tag(r.bank, r.pattern);
                    stored[idx].note     = r.note;
                    stored[idx].velocity = (r.velocity == '0) ? default_vel : r.velocity;
                    stored[idx].length   = (r.length == '0) ? 8'd1 : r.length;
                    armed[idx]           = 1'b1;
                end
                KIND_FETCH:
                begin
                    res = '0;
                    if (tag_ok && armed[idx])
                    begin
                        res.hit      = 1'b1;
                        res.note     = stored[idx].note;
                        res.velocity = stored[idx].velocity;
                        res.length   = stored[idx].length;
                        armed[idx]   = 1'b0;
                    end
                    owed_fetches.push_back(res);
                end
                default:
                begin
                    if (tag_ok)
                        for (int s = 0; s < SLOTS; s++)
                            armed[row + s] = 1'b0;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result transaction with the oldest owed fetch
        function void check_result(fetch_result_t got);
            fetch_result_t want;
            if (owed_fetches.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual hit %0h note %0h vel %0h len %0h",
                         $time, got.hit, got.note, got.velocity, got.length);
                return;
            end
            want = owed_fetches.pop_front();
            results_checked++;
            if (want.hit)
                hits_checked++;
            compare_field("hit", 8'(want.hit), 8'(got.hit));
            compare_field("note_out", want.note, got.note);
            compare_field("velocity_out", want.velocity, got.velocity);
            compare_field("length_out", want.length, got.length);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tnsc_req_if req_bus ();
    tnsc_rsp_if rsp_bus ();
    tnsc_cfg_if cfg_bus ();

    slot_cache_model cache_model;
    slot_addr_t      recent_marks [$];
    bit              quiet;
    bit              hold_request;
    int              cycle_count;
    int              velocity_writes;

    tagged_note_slot_cache_core #(
        .TRACKS (TRACKS),
        .STEPS  (STEPS),
        .SLOTS  (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check transactions, random back-pressure and one long hold-off
    initial
    begin
        int            hold_left;
        fetch_result_t got;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                got.hit      = rsp_bus.hit;
                got.note     = rsp_bus.note_out;
                got.velocity = rsp_bus.velocity_out;
                got.length   = rsp_bus.length_out;
                cache_model.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic note_request_t request_of(
        logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] bank, logic [BYTE_W-1:0] pattern,
        logic [TRACK_W-1:0] track, logic [STEP_W-1:0] step_index, logic [SLOT_W-1:0] slot,
        logic [BYTE_W-1:0] note, logic [BYTE_W-1:0] velocity, logic [BYTE_W-1:0] length);
        note_request_t r;
        r.kind       = kind;
        r.bank       = bank;
        r.pattern    = pattern;
        r.track      = track;
        r.step_index = step_index;
        r.slot       = slot;
        r.note       = note;
        r.velocity   = velocity;
        r.length     = length;
        return r;
    endfunction

    // mostly requests under the live tag aimed at recently marked slots
    function automatic note_request_t random_request();
        note_request_t r;
        slot_addr_t    a;
        int            roll;
        roll = $urandom_range(99);
        if (roll < 35)
            r.kind = KIND_MARK;
        else if (roll < 75)
            r.kind = KIND_FETCH;
        else if (roll < 88)
            r.kind = KIND_SET_ACTIVE;
        else
            r.kind = KIND_DISARM;

        roll = $urandom_range(99);
        if (roll < 80)
        begin
            r.bank    = cache_model.bank_tag;
            r.pattern = cache_model.pattern_tag;
        end
        else if (roll < 95)
        begin
            case ($urandom_range(3))
                0:       begin r.bank = 8'h00; r.pattern = 8'h00; end
                1:       begin r.bank = NO_TAG; r.pattern = NO_TAG; end
                2:       begin r.bank = 8'hAA; r.pattern = 8'h55; end
                default: begin r.bank = 8'h55; r.pattern = 8'hAA; end
            endcase
        end
        else
        begin
            r.bank    = 8'($urandom_range(255));
            r.pattern = 8'($urandom_range(255));
        end

        a = slot_addr_t'(ADDR_W'($urandom_range(ENTRIES - 1)));
        if (recent_marks.size() > 0 &&
            $urandom_range(99) < ((r.kind == KIND_MARK) ? 30 : 70))
            a = recent_marks[$urandom_range(recent_marks.size() - 1)];
        r.track      = a.track;
        r.step_index = a.step_index;
        r.slot       = a.slot;

        r.note     = 8'($urandom_range(255));
        r.velocity = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
        r.length   = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
        return r;
    endfunction

    // offer one request, optionally after idle cycles, and wait for its transaction
    task automatic drive_request(note_request_t r);
        slot_addr_t a;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.kind        <= r.kind;
        req_bus.bank        <= r.bank;
        req_bus.pattern     <= r.pattern;
        req_bus.track       <= r.track;
        req_bus.step_index  <= r.step_index;
        req_bus.slot        <= r.slot;
        req_bus.note_in     <= r.note;
        req_bus.velocity_in <= r.velocity;
        req_bus.length_in   <= r.length;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        cache_model.note_request(r);
        if (r.kind == KIND_MARK)
        begin
            a.track      = r.track;
            a.step_index = r.step_index;
            a.slot       = r.slot;
            recent_marks.push_back(a);
            if (recent_marks.size() > RECENT_DEPTH)
                void'(recent_marks.pop_front());
        end
    endtask

    task automatic finish_phase();
        req_bus.valid <= 1'b0;
    endtask

    // register write only once the pipeline has emptied
    task automatic write_default_velocity(logic [BYTE_W-1:0] value);
        while (cache_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        cache_model.set_default_velocity(value);
        velocity_writes++;
    endtask

    // corner cases of tag handling, defaults, single-shot fetch and step disarm
    task automatic run_directed();
        drive_request(request_of(KIND_FETCH, NO_TAG, NO_TAG, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_MARK, NO_TAG, NO_TAG, 4'd15, 6'd63, 2'd3,
                                 8'hFF, 8'hFF, 8'hFF));
        drive_request(request_of(KIND_FETCH, NO_TAG, NO_TAG, 4'd15, 6'd63, 2'd3,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, NO_TAG, NO_TAG, 4'd15, 6'd63, 2'd3,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_SET_ACTIVE, 8'h00, 8'h00, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_MARK, 8'h00, 8'h00, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_MARK, 8'h00, 8'h00, 4'd0, 6'd0, 2'd1,
                                 8'h5A, 8'h01, 8'hA5));
        drive_request(request_of(KIND_MARK, 8'h00, 8'h00, 4'd0, 6'd0, 2'd2,
                                 8'hA5, 8'h80, 8'h01));
        drive_request(request_of(KIND_MARK, 8'h00, 8'h00, 4'd0, 6'd0, 2'd3,
                                 8'h7F, 8'h7F, 8'h80));
        // same tag again keeps the marks
        drive_request(request_of(KIND_SET_ACTIVE, 8'h00, 8'h00, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        // tag mismatch misses and leaves the tag alone
        drive_request(request_of(KIND_FETCH, 8'h01, 8'h00, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'h00, 8'h01, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'h00, 8'h00, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_DISARM, 8'h00, 8'hFF, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'h00, 8'h00, 4'd0, 6'd0, 2'd2,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_DISARM, 8'h00, 8'h00, 4'd0, 6'd0, 2'd3,
                                 8'hFF, 8'hFF, 8'hFF));
        drive_request(request_of(KIND_FETCH, 8'h00, 8'h00, 4'd0, 6'd0, 2'd1,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'h00, 8'h00, 4'd0, 6'd0, 2'd3,
                                 8'h00, 8'h00, 8'h00));
        // mark under a new tag switches it and drops older marks
        drive_request(request_of(KIND_MARK, 8'h00, 8'h00, 4'd9, 6'd42, 2'd2,
                                 8'h33, 8'h44, 8'h55));
        drive_request(request_of(KIND_MARK, 8'hAA, 8'h55, 4'd6, 6'd21, 2'd1,
                                 8'hC3, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'hAA, 8'h55, 4'd9, 6'd42, 2'd2,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, 8'hAA, 8'h55, 4'd6, 6'd21, 2'd1,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_SET_ACTIVE, NO_TAG, NO_TAG, 4'd0, 6'd0, 2'd0,
                                 8'h00, 8'h00, 8'h00));
        drive_request(request_of(KIND_FETCH, NO_TAG, NO_TAG, 4'd6, 6'd21, 2'd1,
                                 8'h00, 8'h00, 8'h00));
    endtask

    task automatic run_random(int count, int quiet_count);
        for (int i = 0; i < count; i++)
        begin
            quiet = (i < quiet_count);
            drive_request(random_request());
        end
        quiet = 1'b0;
    endtask

    // a mark under a new tag every round, enough to wrap the shared generation
    // count; every few rounds the previous and the newest mark are fetched
    task automatic run_tag_churn(int rounds);
        slot_addr_t        a;
        slot_addr_t        prev;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] p;
        prev = '0;
        for (int i = 0; i < rounds; i++)
        begin
            do
            begin
                b = 8'($urandom_range(255));
                p = 8'($urandom_range(255));
            end
            while (b == cache_model.bank_tag && p == cache_model.pattern_tag);
            a = slot_addr_t'(ADDR_W'($urandom_range(ENTRIES - 1)));
            drive_request(request_of(KIND_MARK, b, p, a.track, a.step_index, a.slot,
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255))));
            if ((i % CHURN_CHECK) == (CHURN_CHECK - 1))
            begin
                drive_request(request_of(KIND_FETCH, b, p, prev.track, prev.step_index,
                                         prev.slot, 8'h00, 8'h00, 8'h00));
                drive_request(request_of(KIND_FETCH, b, p, a.track, a.step_index, a.slot,
                                         8'h00, 8'h00, 8'h00));
            end
            prev = a;
        end
    endtask

    // main sequence
    initial
    begin
        cache_model     = new();
        quiet           = 1'b0;
        hold_request    = 1'b0;
        velocity_writes = 0;
        rst_n               <= 1'b0;
        req_bus.valid       <= 1'b0;
        req_bus.kind        <= KIND_SET_ACTIVE;
        req_bus.bank        <= '0;
        req_bus.pattern     <= '0;
        req_bus.track       <= '0;
        req_bus.step_index  <= '0;
        req_bus.slot        <= '0;
        req_bus.note_in     <= '0;
        req_bus.velocity_in <= '0;
        req_bus.length_in   <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_default_velocity(8'd255);
        run_directed();
        finish_phase();

        // zero default, with the receiver holding off while requests pile up
        write_default_velocity(8'd0);
        hold_request = 1'b1;
        run_random(RANDOM_ITEMS_A, 0);
        finish_phase();

        write_default_velocity(8'd1);
        run_tag_churn(CHURN_ROUNDS);
        finish_phase();

        write_default_velocity(8'($urandom_range(2, 254)));
        run_random(RANDOM_ITEMS_B, QUIET_ITEMS);
        finish_phase();

        // drain
        while (cache_model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d request transactions and %0d velocity settings",
                 cache_model.requests_seen, velocity_writes);
        $display("checked %0d fetch results (%0d hits) across %0d tag changes",
                 cache_model.results_checked, cache_model.hits_checked,
                 cache_model.tag_changes);
        if (cache_model.errors == 0 && cache_model.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
